// File: src/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

	// Field widths of one transfer
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 16;
	localparam int CAP_BITS   = 5;

	// Default table depth and capacity after reset
	localparam int ENTRIES_DEF = 16;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   operation;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
	} rsp_t;

endpackage

// File: src/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement.
//
// Usage:
//   A command (get or put, key, value) is taken at a rising edge where start is
//   high and busy is low. Each command produces exactly one response on the
//   response port, marked by done for one cycle; the receiver cannot stall it.
//   Each command passes through the command register and then the response
//   register, which drives done and the response port.
//   Throughput is one command per cycle while busy is low; a command may follow its
//   predecessor on the next cycle and sees all of that predecessor's table updates.
//   The key search, rank update and eviction choice are one pass of parallel
//   compares between the command register and the response register.
//   capacity_in_use is written through cfg_we / cfg_wdata; the user must write it only while
//   the block is idle, which the block does not enforce; 0 acts as 1 and values above
//   ENTRIES act as ENTRIES. Reset clears all valid flags, ranks and occupancy and sets the
//   capacity to 16; busy stays high until the first clock edge after reset is released.
//   Key and data storage is not cleared; it is only read behind a valid flag.
module lru_key_value_cache_core #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lkvc_pkg::req_t                request,
	input  logic                          cfg_we,
	input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata,
	output logic                          done,
	output lkvc_pkg::rsp_t                response
);
	import lkvc_pkg::*;

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

	// Table state
	logic [KEY_BITS-1:0]   key_q  [ENTRIES];
	logic [VALUE_BITS-1:0] data_q [ENTRIES];
	logic [RANK_W-1:0]     rank_q [ENTRIES];
	logic [RANK_W-1:0]     rank_d [ENTRIES];
	logic [ENTRIES-1:0]    valid_q, valid_d;
	logic [OCC_W-1:0]      occ_q, occ_d;
	logic [CAP_BITS-1:0]   cap_q;
	logic                  busy_q;

	// Command register
	logic valid_s1;
	req_t req_s1;

	// Response register
	logic done_q;
	rsp_t rsp_q;

	// Lookup and replacement decode
	logic [ENTRIES-1:0]    hit_vec, lru_vec, free_vec, free_oh, ins_vec;
	logic                  hit, is_put, evict, install;
	logic [RANK_W-1:0]     hit_rank, lru_rank;
	logic [VALUE_BITS-1:0] hit_data;
	logic [KEY_BITS-1:0]   lru_key;
	logic [CMP_W-1:0]      cap_ext, cap_eff, occ_ext;

	assign busy     = busy_q;
	assign done     = done_q;
	assign response = rsp_q;

	// Control registers: capacity, ready after reset, command valid and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= start && !busy_q;
			done_q   <= valid_s1;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// Command payload
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_s1 <= request;
		end
	end

	// Effective capacity, clamped to 1..ENTRIES
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		occ_ext = CMP_W'(occ_q);
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// Parallel key compare, LRU pick and first free slot
	always_comb begin
		is_put   = (req_s1.operation == OP_PUT);
		lru_rank = RANK_W'(occ_q - OCC_W'(1));
		hit_rank = '0;
		hit_data = '0;
		lru_key  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == req_s1.key);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
			hit_rank   = hit_rank | (hit_vec[i] ? rank_q[i] : '0);
			hit_data   = hit_data | (hit_vec[i] ? data_q[i] : '0);
			lru_key    = lru_key  | (lru_vec[i] ? key_q[i]  : '0);
		end
		hit      = |hit_vec;
		free_vec = ~valid_q;
		free_oh  = free_vec & ~(free_vec - ENTRIES'(1));
		install  = is_put && !hit;
		evict    = install && (occ_ext >= cap_eff);
		ins_vec  = evict ? lru_vec : free_oh;
	end

	// Next valid flags, ranks and occupancy
	always_comb begin
		valid_d = valid_q;
		occ_d   = occ_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
			if (valid_s1 && hit) begin
				// Hit: promote, age the entries that were more recent
				if (hit_vec[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && rank_q[i] < hit_rank) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end else if (valid_s1 && install) begin
				// Miss on put: install as most recent, age all others
				if (ins_vec[i]) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end else if (valid_q[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
		end
		if (valid_s1 && install && !evict) begin
			occ_d = occ_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	// Key and data storage, written on put
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_s1 && is_put && (hit ? hit_vec[i] : ins_vec[i])) begin
				data_q[i] <= req_s1.value;
				key_q[i]  <= req_s1.key;
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.found       <= hit;
			rsp_q.read_value  <= (hit && !is_put) ? hit_data : '0;
			rsp_q.evicted     <= evict;
			rsp_q.evicted_key <= evict ? lru_key : '0;
		end
	end

endmodule

// File: src/lkvc_checker.sv
// Port-level checks for the LRU key/value cache, bound to the top level.
module lkvc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input lkvc_pkg::req_t                request,
	input logic                          done,
	input lkvc_pkg::rsp_t                response
);
	import lkvc_pkg::*;

	// Every command transfer gives a response, and a response comes only from a transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("command transfer without response two cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("response without matching command transfer");

	// A get never evicts
	a_get_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.operation, 2) == OP_GET) |->
			(!response.evicted && response.evicted_key == '0))
		else $error("get reported an eviction");

	// A put followed at once by a get of the same key returns the put value
	a_put_get: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == OP_PUT) ##1
		(start && !busy && request.operation == OP_GET &&
			request.key == $past(request.key)) |->
		##2 (done && response.found && response.read_value == $past(request.value, 3)))
		else $error("get after put of same key did not return the put value");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);

// File: tb/lru_key_value_cache_core_tb.sv
// Self-checking testbench for the LRU key/value cache core.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
	import lkvc_pkg::*;

	localparam int SLOTS         = ENTRIES_DEF;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int POOL_DEPTH    = 24;
	localparam int PRINT_LIMIT   = 40;

	typedef enum logic {
		ROW_ACCESS,
		ROW_CONFIG
	} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CAP_BITS-1:0]  cap;
		req_t                 req;
		logic                 typed;
		rsp_t                 rsp;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                request;
	logic                cfg_we;
	logic [CAP_BITS-1:0] cfg_wdata;
	logic                done;
	rsp_t                response;

	// Typed expectation that travels with the command driven this cycle
	logic                cmd_typed;
	rsp_t                cmd_result;

	// Predictor state
	logic [KEY_BITS-1:0]   cached_key [SLOTS];
	logic [VALUE_BITS-1:0] cached_data[SLOTS];
	logic                  cached_valid[SLOTS];
	int                    cached_rank[SLOTS];
	int                    cached_count;
	logic [CAP_BITS-1:0]   capacity_reg;

	rsp_t      expected_results[$];
	stim_row_t directed_rows[$];
	rsp_t      lookup_result;
	rsp_t      oldest;

	int error_count  = 0;
	int cycle_count  = 0;
	int access_count = 0;
	int hit_count    = 0;
	int evict_count  = 0;
	int cfg_count    = 0;

	lru_key_value_cache_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.response (response)
	);

	always #5ns clk = ~clk;

	// Age valid entries newer than limit, then make slot s the most recent
	function automatic void promote_entry(int s, int limit);
		for (int i = 0; i < SLOTS; i++)
			if (cached_valid[i] && i != s && cached_rank[i] < limit)
				cached_rank[i]++;
		cached_rank[s] = 0;
	endfunction

	// Expected response for one access; updates the cache image
	function automatic rsp_t predict_access(req_t r);
		rsp_t res;
		int   eff_cap;
		int   hit_slot;
		int   slot;
		int   victim;
		int   worst;
		res      = '0;
		eff_cap  = (capacity_reg == 0) ? 1 : ((capacity_reg > SLOTS) ? SLOTS : capacity_reg);
		hit_slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (hit_slot < 0 && cached_valid[i] && cached_key[i] == r.key)
				hit_slot = i;
		if (hit_slot >= 0) begin
			res.found = 1'b1;
			promote_entry(hit_slot, cached_rank[hit_slot]);
			if (r.operation == OP_PUT)
				cached_data[hit_slot] = r.value;
			else
				res.read_value = cached_data[hit_slot];
		end else if (r.operation == OP_PUT) begin
			slot = -1;
			for (int i = 0; i < SLOTS; i++)
				if (slot < 0 && !cached_valid[i])
					slot = i;
			// Full at the capacity in use: drop the least recent entry
			if (cached_count >= eff_cap || slot < 0) begin
				victim = -1;
				worst  = 0;
				for (int i = 0; i < SLOTS; i++)
					if (cached_valid[i] && (victim < 0 || cached_rank[i] > worst)) begin
						victim = i;
						worst  = cached_rank[i];
					end
				if (victim >= 0) begin
					res.evicted         = 1'b1;
					res.evicted_key     = cached_key[victim];
					cached_valid[victim] = 1'b0;
					if (cached_count > 0)
						cached_count--;
					slot = victim;
				end
			end
			if (slot >= 0) begin
				promote_entry(slot, 32'h7fff_ffff);
				cached_valid[slot] = 1'b1;
				cached_key[slot]   = r.key;
				cached_data[slot]  = r.value;
				cached_rank[slot]  = 0;
				cached_count++;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (error_count < PRINT_LIMIT)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
		error_count++;
	endtask

	// Predictor update, response check and run limit, all on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("FAILURE");
				$finish;
			end else begin
				if (done) begin
					if (expected_results.size() == 0) begin
						report_mismatch("unexpected response", 32'(response.read_value),
							32'd0);
					end else begin
						oldest = expected_results.pop_front();
						if (response.found !== oldest.found)
							report_mismatch("found", 32'(response.found),
								32'(oldest.found));
						if (response.read_value !== oldest.read_value)
							report_mismatch("read_value", 32'(response.read_value),
								32'(oldest.read_value));
						if (response.evicted !== oldest.evicted)
							report_mismatch("evicted", 32'(response.evicted),
								32'(oldest.evicted));
						if (response.evicted_key !== oldest.evicted_key)
							report_mismatch("evicted_key", 32'(response.evicted_key),
								32'(oldest.evicted_key));
					end
				end
				if (cfg_we) begin
					capacity_reg = cfg_wdata;
					cfg_count++;
				end
				if (start && !busy) begin
					lookup_result = predict_access(request);
					expected_results.push_back(cmd_typed ? cmd_result : lookup_result);
					access_count++;
					if (lookup_result.found)
						hit_count++;
					if (lookup_result.evicted)
						evict_count++;
				end
			end
		end
	end

	// Drive one command and hold it until the transfer
	task automatic send_access(req_t r, logic typed, rsp_t want);
		start      <= 1'b1;
		request    <= r;
		cmd_typed  <= typed;
		cmd_result <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Stop issuing and let every outstanding response come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_BITS-1:0] cap);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic add_row(row_kind_t kind, logic [CAP_BITS-1:0] cap, op_t op,
		logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value, logic typed,
		logic found, logic [VALUE_BITS-1:0] rd, logic ev, logic [KEY_BITS-1:0] evk);
		stim_row_t row;
		row.kind            = kind;
		row.cap             = cap;
		row.req.operation   = op;
		row.req.key         = key;
		row.req.value       = value;
		row.typed           = typed;
		row.rsp.found       = found;
		row.rsp.read_value  = rd;
		row.rsp.evicted     = ev;
		row.rsp.evicted_key = evk;
		directed_rows.push_back(row);
	endtask

	initial begin
		req_t                r;
		logic [KEY_BITS-1:0] key_pool[POOL_DEPTH];
		logic [CAP_BITS-1:0] phase_caps[$];
		int                  per_phase;
		int                  span;
		int                  pool_size;
		int                  burst_left;
		int                  pick;
		bit                  gaps_on;

		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		cmd_typed = 1'b0;
		cmd_result = '0;
		for (int i = 0; i < SLOTS; i++) begin
			cached_key[i]   = '0;
			cached_data[i]  = '0;
			cached_valid[i] = 1'b0;
			cached_rank[i]  = 0;
		end
		cached_count = 0;
		capacity_reg = CAP_RESET;

		// Directed table: empty-cache misses, extremes, capacity corner cases
		add_row(ROW_ACCESS, 0, OP_GET, 16'h0000, 16'h0000, 1, 0, 16'h0000, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_GET, 16'hffff, 16'hffff, 1, 0, 16'h0000, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h0000, 16'hffff, 1, 0, 16'h0000, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'hffff, 16'h0000, 1, 0, 16'h0000, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_GET, 16'h0000, 16'h0000, 1, 1, 16'hffff, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'hffff, 16'haaaa, 1, 1, 16'h0000, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_GET, 16'hffff, 16'h1234, 1, 1, 16'haaaa, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h5555, 16'h5555, 1, 0, 16'h0000, 0, 16'h0000);
		add_row(ROW_ACCESS, 0, OP_GET, 16'h1234, 16'h0000, 0, 0, 0, 0, 0);
		// Capacity dropped below occupancy: each put miss evicts one
		add_row(ROW_CONFIG, 5'd2, OP_GET, 0, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h1234, 16'h0001, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h4321, 16'h0002, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_GET, 16'h5555, 16'h0000, 0, 0, 0, 0, 0);
		// Zero capacity behaves as one entry
		add_row(ROW_CONFIG, 5'd0, OP_GET, 0, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h0001, 16'hffff, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h0002, 16'h0000, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_GET, 16'h0002, 16'h0000, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_GET, 16'h0001, 16'h0000, 0, 0, 0, 0, 0);
		// Oversized capacity clamps to the table depth
		add_row(ROW_CONFIG, 5'd31, OP_GET, 0, 0, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_GET, 16'h8000, 16'h0000, 0, 0, 0, 0, 0);
		add_row(ROW_ACCESS, 0, OP_PUT, 16'h0002, 16'h5a5a, 0, 0, 0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG) begin
				write_capacity(directed_rows[i].cap);
			end else begin
				send_access(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
			end
		end

		// Random phases, one capacity each, extremes included
		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd3, 5'd17, 5'd0, 5'd16};
		phase_caps[7] = CAP_BITS'($urandom_range(0, 31));
		per_phase = RANDOM_ITEMS / phase_caps.size();
		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			span      = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p]);
			pool_size = span + 3;
			for (int k = 0; k < POOL_DEPTH; k++)
				key_pool[k] = KEY_BITS'($urandom);
			// First phase runs back to back with no idle cycles
			gaps_on    = (p != 0);
			burst_left = $urandom_range(1, 40);
			for (int n = 0; n < per_phase; n++) begin
				pick = $urandom_range(0, 99);
				r.operation = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
				if (pick < 80)
					r.key = key_pool[$urandom_range(0, pool_size - 1)];
				else if (pick < 90)
					r.key = KEY_BITS'($urandom);
				else if (pick < 95)
					r.key = '0;
				else
					r.key = '1;
				pick = $urandom_range(0, 9);
				r.value = (pick == 0) ? '0 : ((pick == 1) ? '1 : VALUE_BITS'($urandom));
				send_access(r, 1'b0, '0);
				burst_left--;
				if (burst_left == 0) begin
					if (gaps_on && $urandom_range(0, 3) != 0) begin
						start <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
					burst_left = $urandom_range(1, 40);
				end
			end
		end

		drain_results();
		$display("Ran %0d transfers: %0d hits, %0d evictions, %0d capacity writes",
			access_count, hit_count, evict_count, cfg_count);
		$display("Capacity settings spanned zero, one, mid values, full depth and oversize");
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d responses missing", error_count,
				expected_results.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
